// File: src/fwc_pkg.sv
// Shared types and codes for the queue with removal by id.
package fwc_pkg;

  localparam logic [1:0] OP_ENQ    = 2'd0;
  localparam logic [1:0] OP_DEQ    = 2'd1;
  localparam logic [1:0] OP_CANCEL = 2'd2;
  localparam logic [1:0] OP_SEARCH = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] order_id;
    logic [15:0] customer_tag;
    logic [7:0]  product_code;
    logic [15:0] quantity;
    logic [31:0] bill;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_id;
    logic [15:0] out_customer;
    logic [7:0]  out_product;
    logic [15:0] out_quantity;
    logic [31:0] out_bill;
    logic [4:0]  occupancy;
  } out_t;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] customer;
    logic [7:0]  product;
    logic [15:0] quantity;
    logic [31:0] bill;
  } entry_t;

endpackage

// File: src/fwc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fwc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                              clk,
  input  logic                                              we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]       waddr,
  input  logic [WIDTH-1:0]                                  wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]       raddr,
  output logic [WIDTH-1:0]                                  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/fifo_with_cancel_by_id.sv
// Top level: ordered queue of tagged entries with dequeue, cancel and search by id.
//
//   channel   signals               handshake
//   --------  --------------------  ------------------------------------------
//   command   start, busy, cmd      transaction taken when start and not busy
//   result    done, result          one-cycle strobe, always taken
//
// Timing: an enqueue, or any other transaction on an empty queue, shows its
// result the cycle after it is taken, and the block is ready again in that same
// cycle. A search reads one entry per cycle from the entry RAM and finishes at
// the first match; a search or cancel that misses reads every entry first.
// Dequeue and cancel find their entry, then move every later entry down one
// slot, one RAM read and one write per cycle, and nothing moves when the
// removed entry is the tail. The single read port of the RAM is why scan
// and shift handle one entry at a time.
// Reset clears the state, entry count and scan index; the RAM contents need no clearing.
// The receiver cannot stall: done is high for exactly one cycle per result.
module fifo_with_cancel_by_id #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  fwc_pkg::in_t  cmd,
  output logic          done,
  output fwc_pkg::out_t result
);
  import fwc_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);
  localparam logic [CW:0]   DEPTH_W    = (CW + 1)'(QUEUE_DEPTH);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;

  // control registers
  logic [1:0]    state;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  // payload registers
  logic [1:0]    op;
  logic [15:0]   key;
  entry_t        found;

  // RAM port signals
  logic          we;
  logic [AW-1:0] waddr;
  entry_t        wdata;
  logic [AW-1:0] raddr;
  entry_t        rdata;

  logic [CW:0]   idx_p1;
  logic [CW:0]   idx_p2;
  logic [CW:0]   count_w;
  logic          more;
  logic          hit;
  logic          accept;

  assign accept  = start && !busy;
  assign busy    = (state != S_IDLE);
  assign idx_p1  = {1'b0, idx} + (CW + 1)'(1);
  assign idx_p2  = {1'b0, idx} + (CW + 1)'(2);
  assign count_w = {1'b0, count};
  // another entry follows the one at idx
  assign more    = (idx_p1 < count_w);
  // dequeue always takes the head
  assign hit     = (op == OP_DEQ) || (rdata.id == key);

  fwc_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // RAM access: scan reads ahead by one entry, the shift writes one slot
  // behind the entry it reads, so a read never meets a write to the same slot.
  always_comb begin
    we    = 1'b0;
    waddr = count[AW-1:0];
    wdata = '{id: cmd.order_id, customer: cmd.customer_tag, product: cmd.product_code,
              quantity: cmd.quantity, bill: cmd.bill};
    raddr = '0;
    case (state)
      S_IDLE: begin
        we = accept && (cmd.op == OP_ENQ) && (count != FULL_COUNT);
      end
      S_SCAN: begin
        raddr = (idx_p1 < DEPTH_W) ? idx_p1[AW-1:0] : '0;
      end
      S_SHIFT: begin
        we    = more;
        waddr = idx[AW-1:0];
        wdata = rdata;
        raddr = (idx_p2 < DEPTH_W) ? idx_p2[AW-1:0] : '0;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      idx   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            op  <= cmd.op;
            key <= cmd.order_id;
            idx <= '0;
            result <= '0;
            if (cmd.op == OP_ENQ) begin
              // finish at once: store at the tail or refuse when full
              done <= 1'b1;
              if (count == FULL_COUNT) begin
                result.status    <= ST_FULL;
                result.occupancy <= 5'(count);
              end else begin
                count            <= count + CW'(1);
                result.status    <= ST_OK;
                result.occupancy <= 5'(count + CW'(1));
              end
            end else if (count == '0) begin
              done             <= 1'b1;
              result.status    <= ST_MISS;
              result.occupancy <= 5'(count);
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (hit) begin
            found <= rdata;
            if (op == OP_SEARCH) begin
              done   <= 1'b1;
              result <= '{status: ST_OK, out_id: rdata.id, out_customer: rdata.customer,
                          out_product: rdata.product, out_quantity: rdata.quantity,
                          out_bill: rdata.bill, occupancy: 5'(count)};
              state  <= S_IDLE;
            end else if (more) begin
              // close the gap behind the removed entry
              state <= S_SHIFT;
            end else begin
              done   <= 1'b1;
              count  <= count - CW'(1);
              result <= '{status: ST_OK, out_id: rdata.id, out_customer: rdata.customer,
                          out_product: rdata.product, out_quantity: rdata.quantity,
                          out_bill: rdata.bill, occupancy: 5'(count - CW'(1))};
              state  <= S_IDLE;
            end
          end else if (more) begin
            idx <= idx_p1[CW-1:0];
          end else begin
            done   <= 1'b1;
            result <= '0;
            result.status    <= ST_MISS;
            result.occupancy <= 5'(count);
            state  <= S_IDLE;
          end
        end
        S_SHIFT: begin
          if (more) begin
            idx <= idx_p1[CW-1:0];
          end else begin
            done   <= 1'b1;
            count  <= count - CW'(1);
            result <= '{status: ST_OK, out_id: found.id, out_customer: found.customer,
                        out_product: found.product, out_quantity: found.quantity,
                        out_bill: found.bill, occupancy: 5'(count - CW'(1))};
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // a result always leaves the block ready for the next transaction
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // the entry count never passes the depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("entry count above queue depth");

  // a refused enqueue only happens on a full queue
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ST_FULL) |-> (count == FULL_COUNT))
    else $error("full status on a queue with room");

  // a taken transaction is either still at work or answered
  a_no_loss: assert property (@(posedge clk) disable iff (rst)
    accept |=> (busy || done))
    else $error("transaction dropped");

  // the shift never writes past the valid entries
  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT && we) |-> (idx_p1 < count_w))
    else $error("shift write beyond tail");

endmodule

// File: bench/fifo_with_cancel_by_id_tb.sv
// Self-checking testbench for the order queue with dequeue, cancel and search by id.
`timescale 1ns / 100ps

module fifo_with_cancel_by_id_tb;
  import fwc_pkg::*;

  localparam int QUEUE_DEPTH = 16;
  // Cycles with no transaction on either side before the run is declared hung.
  // The slowest correct gap is a long sender idle stretch plus one full scan.
  localparam int STALL_LIMIT = 2000;
  // Settle time after the last result: one full dequeue/cancel pass, doubled.
  localparam int DRAIN_CYCLES = 2 * QUEUE_DEPTH + 4;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  in_t  cmd;
  logic done;
  out_t result;

  fifo_with_cancel_by_id #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .done(done),
    .result(result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the queue contents, head at index 0.
  entry_t held_orders[$];
  // Results owed by the block, oldest first.
  out_t   owed_results[$];

  int sender_idle_pct;
  int mismatch_count;
  int stall_cycles;
  int ops_taken[4];
  int refused_full;
  int lookup_hits;
  int lookup_misses;
  int peak_occupancy;

  task automatic log_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      log_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    end
  endtask

  // Apply one accepted command to the shadow queue and return the result it owes.
  function automatic out_t apply_order_op(in_t c);
    out_t   r;
    entry_t e;
    int     pos;
    r = '0;
    pos = -1;
    ops_taken[c.op]++;
    case (c.op)
      OP_ENQ: begin
        if (held_orders.size() >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
          refused_full++;
        end else begin
          e.id = c.order_id;
          e.customer = c.customer_tag;
          e.product = c.product_code;
          e.quantity = c.quantity;
          e.bill = c.bill;
          held_orders.push_back(e);
          r.status = ST_OK;
        end
      end
      OP_DEQ: begin
        if (held_orders.size() > 0) begin
          pos = 0;
        end
      end
      default: begin
        // Cancel and search both act on the match nearest the head.
        for (int i = 0; i < held_orders.size() && pos < 0; i++) begin
          if (held_orders[i].id == c.order_id) begin
            pos = i;
          end
        end
      end
    endcase
    if (pos >= 0) begin
      r.status = ST_OK;
      r.out_id = held_orders[pos].id;
      r.out_customer = held_orders[pos].customer;
      r.out_product = held_orders[pos].product;
      r.out_quantity = held_orders[pos].quantity;
      r.out_bill = held_orders[pos].bill;
      if (c.op != OP_SEARCH) begin
        held_orders.delete(pos);
      end
      lookup_hits++;
    end else if (c.op != OP_ENQ) begin
      r.status = ST_MISS;
      lookup_misses++;
    end
    r.occupancy = 5'(held_orders.size());
    if (held_orders.size() > peak_occupancy) begin
      peak_occupancy = held_orders.size();
    end
    return r;
  endfunction

  // Send one command: idle at random first, then hold start until busy is low.
  // Leave start high on return so back-to-back commands need no second drive.
  task automatic issue_order(in_t c);
    if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy);
    owed_results.push_back(apply_order_op(c));
  endtask

  function automatic in_t make_order(logic [1:0] op, logic [15:0] id);
    in_t c;
    c.op = op;
    c.order_id = id;
    c.customer_tag = 16'($urandom);
    c.product_code = 8'($urandom);
    c.quantity = 16'($urandom);
    c.bill = $urandom;
    return c;
  endfunction

  // Draw a random command. Filling mode leans on enqueue so the queue reaches
  // full; draining mode leans on removal so it empties out again.
  function automatic in_t make_random_order(bit filling);
    in_t c;
    int  r;
    r = $urandom_range(99);
    c = make_order(OP_ENQ, '0);
    if (filling) begin
      c.op = (r < 60) ? OP_ENQ : (r < 70) ? OP_DEQ : (r < 85) ? OP_CANCEL : OP_SEARCH;
    end else begin
      c.op = (r < 15) ? OP_ENQ : (r < 50) ? OP_DEQ : (r < 80) ? OP_CANCEL : OP_SEARCH;
    end
    // Aim most lookups at held ids; draw stored ids from a small pool so
    // duplicates are common, with an occasional id from the whole range.
    if (c.op != OP_ENQ && held_orders.size() > 0 && $urandom_range(3) != 0) begin
      c.order_id = held_orders[$urandom_range(held_orders.size() - 1)].id;
    end else if ($urandom_range(3) == 0) begin
      c.order_id = 16'($urandom);
    end else begin
      c.order_id = 16'($urandom_range(31));
    end
    return c;
  endfunction

  // Check every strobed result against the oldest owed one.
  always @(posedge clk) begin
    out_t want;
    if (!rst && done) begin
      if (owed_results.size() == 0) begin
        log_mismatch($sformatf("unexpected result 0x%0h", result));
      end else begin
        want = owed_results.pop_front();
        check_field("status", 32'(result.status), 32'(want.status));
        check_field("out_id", 32'(result.out_id), 32'(want.out_id));
        check_field("out_customer", 32'(result.out_customer), 32'(want.out_customer));
        check_field("out_product", 32'(result.out_product), 32'(want.out_product));
        check_field("out_quantity", 32'(result.out_quantity), 32'(want.out_quantity));
        check_field("out_bill", result.out_bill, want.out_bill);
        check_field("occupancy", 32'(result.occupancy), 32'(want.occupancy));
      end
    end
  end

  // Hang detector: reset the count on any transaction in either direction.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("** fifo_with_cancel_by_id: FAILED **");
      $finish;
    end
  end

  // Every lookup and removal on an empty queue must miss.
  task automatic test_empty_queue();
    issue_order(make_order(OP_DEQ, 16'h0000));
    issue_order(make_order(OP_CANCEL, 16'hFFFF));
    issue_order(make_order(OP_SEARCH, 16'h0000));
  endtask

  // Field extremes, duplicate ids, cancel from the middle and a missed cancel.
  task automatic test_order_and_duplicates();
    in_t c;
    c = '1;
    c.op = OP_ENQ;
    issue_order(c);
    c = '0;
    issue_order(c);
    issue_order(make_order(OP_ENQ, 16'hFFFF));
    issue_order(make_order(OP_ENQ, 16'h0005));
    issue_order(make_order(OP_CANCEL, 16'h0000));
    issue_order(make_order(OP_SEARCH, 16'hFFFF));
    issue_order(make_order(OP_DEQ, 16'h1234));
    issue_order(make_order(OP_CANCEL, 16'h0007));
  endtask

  // Fill to the brim, get one enqueue refused, then cancel the tail entry.
  task automatic test_full_queue();
    int n;
    n = QUEUE_DEPTH - held_orders.size();
    for (int i = 0; i < n; i++) begin
      issue_order(make_order(OP_ENQ, 16'h0100 + 16'(i)));
    end
    issue_order(make_order(OP_ENQ, 16'hBEEF));
    issue_order(make_order(OP_CANCEL, 16'h0100 + 16'(n - 1)));
  endtask

  // Random commands; flip between filling and draining now and then so the
  // occupancy sweeps from empty to full and back.
  task automatic test_random_traffic(int count, int idle_pct);
    bit filling;
    sender_idle_pct = idle_pct;
    filling = 1'b1;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(23) == 0) begin
        filling = !filling;
      end
      issue_order(make_random_order(filling));
    end
  endtask

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    cmd <= '0;
    mismatch_count = 0;
    refused_full = 0;
    lookup_hits = 0;
    lookup_misses = 0;
    peak_occupancy = 0;
    ops_taken = '{default: 0};
    sender_idle_pct = 20;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_empty_queue();
    test_order_and_duplicates();
    test_full_queue();
    test_random_traffic(360, 20);
    test_random_traffic(360, 72);
    test_random_traffic(360, 0);

    // Drop start right at the last accepting edge, wait for every owed result,
    // then let the block settle.
    start <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d enqueue (%0d refused as full), %0d dequeue, %0d cancel, %0d search",
             ops_taken[OP_ENQ], refused_full, ops_taken[OP_DEQ], ops_taken[OP_CANCEL],
             ops_taken[OP_SEARCH]);
    $display("lookups/removals: %0d hit, %0d missed; peak occupancy %0d; %0d mismatches",
             lookup_hits, lookup_misses, peak_occupancy, mismatch_count);
    if (mismatch_count == 0) begin
      $display("** fifo_with_cancel_by_id: PASSED **");
    end else begin
      $display("** fifo_with_cancel_by_id: FAILED **");
    end
    $finish;
  end

endmodule
